/* design/rmq_pkg.sv */
package rmq_pkg;

  localparam int FRAC_BITS = 14;
  // Matrix entry width and derived internal widths.
  localparam int MW    = 16;
  localparam int SW    = MW + 3;
  localparam int MAGW  = MW + 1;
  localparam int PW    = MW + 1;
  localparam int RADW  = MAGW + FRAC_BITS - 2;
  localparam int RAD2  = RADW + (RADW % 2);
  localparam int ROOTW = RAD2 / 2;
  localparam int DIVW  = ROOTW + 2;
  localparam int NUMW  = PW + FRAC_BITS + 1;
  localparam int LANES = 3;
  localparam int VW    = 16;
  localparam int WW    = 15;
  localparam int PIVW  = 2;

  localparam logic [PIVW-1:0] PIV_X = 2'd0;
  localparam logic [PIVW-1:0] PIV_Y = 2'd1;
  localparam logic [PIVW-1:0] PIV_Z = 2'd2;
  localparam logic [PIVW-1:0] PIV_W = 2'd3;

  typedef struct packed {
    logic [PIVW-1:0]            piv;
    logic [LANES-1:0]           neg;
    logic [LANES-1:0][PW-1:0]   mag;
  } sq_side_t;

  typedef struct packed {
    logic [PIVW-1:0]  piv;
    logic [LANES-1:0] neg;
    logic [ROOTW-1:0] root;
  } dv_side_t;

endpackage

/* design/rmq_front.sv */
module rmq_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [rmq_pkg::MW-1:0]     m00_i,
  input  logic signed [rmq_pkg::MW-1:0]     m01_i,
  input  logic signed [rmq_pkg::MW-1:0]     m02_i,
  input  logic signed [rmq_pkg::MW-1:0]     m10_i,
  input  logic signed [rmq_pkg::MW-1:0]     m11_i,
  input  logic signed [rmq_pkg::MW-1:0]     m12_i,
  input  logic signed [rmq_pkg::MW-1:0]     m20_i,
  input  logic signed [rmq_pkg::MW-1:0]     m21_i,
  input  logic signed [rmq_pkg::MW-1:0]     m22_i,
  output logic                              valid_o,
  output logic [rmq_pkg::RAD2-1:0]          rad_o,
  output rmq_pkg::sq_side_t                 side_o
);
  import rmq_pkg::*;

  localparam logic signed [SW-1:0] ONE = SW'(2**FRAC_BITS);

  logic                      va_q;
  logic [3:0][MAGW-1:0]      mag_d, mag_q;
  logic [5:0][PW-1:0]        pm_d, pm_q;
  logic [5:0]                pn_d, pn_q;

  logic                      vb_q;
  logic [RAD2-1:0]           rad_d, rad_q;
  sq_side_t                  side_d, side_q;

  always_comb begin
    logic signed [SW-1:0] s [4];
    logic signed [SW-1:0] sa;
    logic signed [PW-1:0] p [6];
    logic signed [PW-1:0] pa;
    s[0] = ONE + SW'(m00_i) - SW'(m11_i) - SW'(m22_i);
    s[1] = ONE - SW'(m00_i) + SW'(m11_i) - SW'(m22_i);
    s[2] = ONE - SW'(m00_i) - SW'(m11_i) + SW'(m22_i);
    s[3] = ONE + SW'(m00_i) + SW'(m11_i) + SW'(m22_i);
    for (int i = 0; i < 4; i++) begin
      sa = s[i][SW-1] ? -s[i] : s[i];
      mag_d[i] = sa[MAGW-1:0];
    end
    p[0] = PW'(m01_i) + PW'(m10_i);
    p[1] = PW'(m02_i) + PW'(m20_i);
    p[2] = PW'(m12_i) + PW'(m21_i);
    p[3] = PW'(m12_i) - PW'(m21_i);
    p[4] = PW'(m20_i) - PW'(m02_i);
    p[5] = PW'(m01_i) - PW'(m10_i);
    for (int i = 0; i < 6; i++) begin
      pa = p[i][PW-1] ? -p[i] : p[i];
      pm_d[i] = pa;
      pn_d[i] = p[i][PW-1];
    end
  end

  // Pivot search: a later candidate wins only when strictly larger.
  always_comb begin
    logic [PIVW-1:0] piv;
    logic [MAGW-1:0] best;
    logic [2:0][2:0] sel;
    piv  = PIV_X;
    best = mag_q[0];
    if (mag_q[1] > best) begin
      piv  = PIV_Y;
      best = mag_q[1];
    end
    if (mag_q[2] > best) begin
      piv  = PIV_Z;
      best = mag_q[2];
    end
    if (mag_q[3] > best) begin
      piv  = PIV_W;
      best = mag_q[3];
    end
    case (piv)
      PIV_X:   sel = {3'd3, 3'd1, 3'd0};
      PIV_Y:   sel = {3'd4, 3'd2, 3'd0};
      PIV_Z:   sel = {3'd5, 3'd2, 3'd1};
      default: sel = {3'd5, 3'd4, 3'd3};
    endcase
    side_d.piv = piv;
    for (int l = 0; l < LANES; l++) begin
      side_d.mag[l] = pm_q[sel[l]];
      side_d.neg[l] = pn_q[sel[l]];
    end
    rad_d = RAD2'(best) << (FRAC_BITS - 2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q  <= mag_d;
      pm_q   <= pm_d;
      pn_q   <= pn_d;
      rad_q  <= rad_d;
      side_q <= side_d;
    end
  end

  assign valid_o = vb_q;
  assign rad_o   = rad_q;
  assign side_o  = side_q;

endmodule

/* design/rmq_sqrt.sv */
module rmq_sqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [rmq_pkg::RAD2-1:0]      rad_i,
  input  logic [SIDE_W-1:0]             side_i,
  output logic                          valid_o,
  output logic [rmq_pkg::ROOTW-1:0]     root_o,
  output logic [SIDE_W-1:0]             side_o
);
  import rmq_pkg::*;

  // One root bit per stage, most significant first.
  logic [ROOTW-1:0]              v_q;
  logic [ROOTW-1:0][RAD2-1:0]    rad_q;
  logic [ROOTW-1:0][ROOTW+1:0]   rem_q;
  logic [ROOTW-1:0][ROOTW-1:0]   root_q;
  logic [ROOTW-1:0][SIDE_W-1:0]  side_q;

  for (genvar k = 0; k < ROOTW; k++) begin : g_stage
    logic                v_in;
    logic [RAD2-1:0]     rad_in;
    logic [ROOTW+1:0]    rem_in;
    logic [ROOTW-1:0]    root_in;
    logic [SIDE_W-1:0]   side_in;
    logic [ROOTW+3:0]    r, t;
    logic                ge;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign r  = {rem_in, rad_in[RAD2-1 -: 2]};
    assign t  = {2'b00, root_in, 2'b01};
    assign ge = (r >= t);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= rad_in << 2;
        rem_q[k]  <= ge ? (ROOTW+2)'(r - t) : r[ROOTW+1:0];
        root_q[k] <= {root_in[ROOTW-2:0], ge};
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[ROOTW-1];
  assign root_o  = root_q[ROOTW-1];
  assign side_o  = side_q[ROOTW-1];

endmodule

/* design/rmq_div.sv */
module rmq_div #(
  parameter int SIDE_W = 1
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         en_i,
  input  logic                                         valid_i,
  input  logic [rmq_pkg::LANES-1:0][rmq_pkg::NUMW-1:0] num_i,
  input  logic [rmq_pkg::DIVW-1:0]                     den_i,
  input  logic [SIDE_W-1:0]                            side_i,
  output logic                                         valid_o,
  output logic [rmq_pkg::LANES-1:0][rmq_pkg::NUMW-1:0] quo_o,
  output logic [SIDE_W-1:0]                            side_o
);
  import rmq_pkg::*;

  // Restoring division, one quotient bit per stage, lanes share the divisor.
  logic [NUMW-1:0]                        v_q;
  logic [NUMW-1:0][DIVW-1:0]              den_q;
  logic [NUMW-1:0][LANES-1:0][NUMW-1:0]   num_q;
  logic [NUMW-1:0][LANES-1:0][DIVW-1:0]   rem_q;
  logic [NUMW-1:0][LANES-1:0][NUMW-1:0]   quo_q;
  logic [NUMW-1:0][SIDE_W-1:0]            side_q;

  for (genvar k = 0; k < NUMW; k++) begin : g_stage
    logic                          v_in;
    logic [DIVW-1:0]               den_in;
    logic [LANES-1:0][NUMW-1:0]    num_in;
    logic [LANES-1:0][DIVW-1:0]    rem_in;
    logic [LANES-1:0][NUMW-1:0]    quo_in;
    logic [SIDE_W-1:0]             side_in;
    logic [LANES-1:0][DIVW-1:0]    rem_d;
    logic [LANES-1:0][NUMW-1:0]    quo_d;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign den_in  = den_i;
      assign num_in  = num_i;
      assign rem_in  = '0;
      assign quo_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign den_in  = den_q[k-1];
      assign num_in  = num_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign side_in = side_q[k-1];
    end

    always_comb begin
      logic [DIVW:0] r;
      logic          ge;
      for (int l = 0; l < LANES; l++) begin
        r        = {rem_in[l], num_in[l][NUMW-1]};
        ge       = (r >= {1'b0, den_in});
        rem_d[l] = ge ? DIVW'(r - {1'b0, den_in}) : r[DIVW-1:0];
        quo_d[l] = {quo_in[l][NUMW-2:0], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k]  <= den_in;
        rem_q[k]  <= rem_d;
        quo_q[k]  <= quo_d;
        side_q[k] <= side_in;
        for (int l = 0; l < LANES; l++) begin
          num_q[k][l] <= num_in[l] << 1;
        end
      end
    end
  end

  assign valid_o = v_q[NUMW-1];
  assign quo_o   = quo_q[NUMW-1];
  assign side_o  = side_q[NUMW-1];

endmodule

/* design/rotation_matrix_to_quaternion_core.sv */
// Rotation matrix to quaternion (Shepperd's method), fixed point Q2.14.
// Input channel: valid_i/stall_o with the nine entries m00_i..m22_i; a matrix
// is taken at a clock edge where valid_i is high and stall_o is low.
// Output channel: valid_o/stall_i with quat_x_o, quat_y_o, quat_z_o, quat_w_o
// and pivot_index_o; a result is taken when valid_o is high and stall_i low.
// One result per matrix, in order. An accepted matrix passes through two
// front stages (sums, pivot pick), fifteen square-root stages (one root
// bit each), thirty-two divider stages (one quotient bit each, three lanes
// in parallel) and one output register. Throughput is one matrix per cycle
// while stall_o is low; no stage iterates.
// When the receiver stalls, the output register holds its result and one
// more result is caught in a skid register; only then does stall_o rise and
// the whole pipeline freeze until the receiver takes the held result.
// Reset (rst_ni low, asynchronous) empties every stage and both output
// registers; no transaction is in flight afterwards.
module rotation_matrix_to_quaternion_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            stall_o,
  input  logic signed [rmq_pkg::MW-1:0]   m00_i,
  input  logic signed [rmq_pkg::MW-1:0]   m01_i,
  input  logic signed [rmq_pkg::MW-1:0]   m02_i,
  input  logic signed [rmq_pkg::MW-1:0]   m10_i,
  input  logic signed [rmq_pkg::MW-1:0]   m11_i,
  input  logic signed [rmq_pkg::MW-1:0]   m12_i,
  input  logic signed [rmq_pkg::MW-1:0]   m20_i,
  input  logic signed [rmq_pkg::MW-1:0]   m21_i,
  input  logic signed [rmq_pkg::MW-1:0]   m22_i,
  output logic                            valid_o,
  input  logic                            stall_i,
  output logic signed [rmq_pkg::VW-1:0]   quat_x_o,
  output logic signed [rmq_pkg::VW-1:0]   quat_y_o,
  output logic signed [rmq_pkg::VW-1:0]   quat_z_o,
  output logic [rmq_pkg::WW-1:0]          quat_w_o,
  output logic [rmq_pkg::PIVW-1:0]        pivot_index_o
);
  import rmq_pkg::*;

  localparam int SQ_SIDE_W = $bits(sq_side_t);
  localparam int DV_SIDE_W = $bits(dv_side_t);

  logic                          en;
  logic                          fr_v, sq_v, dv_v;
  logic [RAD2-1:0]               fr_rad;
  sq_side_t                      fr_side, sq_side;
  logic [SQ_SIDE_W-1:0]          sq_side_vec;
  logic [ROOTW-1:0]              sq_root;
  logic [LANES-1:0][NUMW-1:0]    dv_num, dv_quo;
  logic [DIVW-1:0]               dv_den;
  dv_side_t                      dv_side_in, dv_side;
  logic [DV_SIDE_W-1:0]          dv_side_vec;

  logic signed [VW-1:0]          x_d, y_d, z_d;
  logic [WW-1:0]                 w_d;

  logic                          out_v_q, skid_v_q;
  logic signed [VW-1:0]          x_q, y_q, z_q, sx_q, sy_q, sz_q;
  logic [WW-1:0]                 w_q, sw_q;
  logic [PIVW-1:0]               p_q, sp_q;

  assign en      = !skid_v_q;
  assign stall_o = skid_v_q;

  rmq_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid_i),
    .m00_i   (m00_i),
    .m01_i   (m01_i),
    .m02_i   (m02_i),
    .m10_i   (m10_i),
    .m11_i   (m11_i),
    .m12_i   (m12_i),
    .m20_i   (m20_i),
    .m21_i   (m21_i),
    .m22_i   (m22_i),
    .valid_o (fr_v),
    .rad_o   (fr_rad),
    .side_o  (fr_side)
  );

  rmq_sqrt #(
    .SIDE_W (SQ_SIDE_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_v),
    .rad_i   (fr_rad),
    .side_i  (fr_side),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .side_o  (sq_side_vec)
  );

  assign sq_side = sq_side_vec;

  // Dividend is |pair| * 2^FRAC_BITS plus half the divisor 4a.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      dv_num[l] = (NUMW'(sq_side.mag[l]) << FRAC_BITS) + NUMW'({sq_root, 1'b0});
    end
    dv_den          = {sq_root, 2'b00};
    dv_side_in.piv  = sq_side.piv;
    dv_side_in.neg  = sq_side.neg;
    dv_side_in.root = sq_root;
  end

  rmq_div #(
    .SIDE_W (DV_SIDE_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_v),
    .num_i   (dv_num),
    .den_i   (dv_den),
    .side_i  (dv_side_in),
    .valid_o (dv_v),
    .quo_o   (dv_quo),
    .side_o  (dv_side_vec)
  );

  assign dv_side = dv_side_vec;

  function automatic logic signed [VW-1:0] sat_v(input logic signed [NUMW:0] v);
    logic signed [NUMW:0] hi, lo;
    hi = (NUMW+1)'(2**(VW-1) - 1);
    lo = -(NUMW+1)'(2**(VW-1));
    if (v > hi) begin
      return VW'(hi);
    end else if (v < lo) begin
      return VW'(lo);
    end
    return v[VW-1:0];
  endfunction

  always_comb begin
    logic signed [NUMW:0] lv [LANES];
    logic signed [NUMW:0] comp [4];
    logic signed [NUMW:0] whi;
    logic [1:0]           li;
    for (int l = 0; l < LANES; l++) begin
      if (dv_side.root == '0) begin
        lv[l] = '0;
      end else if (dv_side.neg[l]) begin
        lv[l] = -$signed({1'b0, dv_quo[l]});
      end else begin
        lv[l] = $signed({1'b0, dv_quo[l]});
      end
    end
    for (int j = 0; j < 4; j++) begin
      li = (2'(j) < dv_side.piv) ? 2'(j) : 2'(j - 1);
      if (2'(j) == dv_side.piv) begin
        comp[j] = $signed({{(NUMW+1-ROOTW){1'b0}}, dv_side.root});
      end else begin
        comp[j] = lv[li];
      end
    end
    // Keep the scalar part non-negative.
    if (comp[3][NUMW]) begin
      for (int j = 0; j < 4; j++) begin
        comp[j] = -comp[j];
      end
    end
    x_d = sat_v(comp[0]);
    y_d = sat_v(comp[1]);
    z_d = sat_v(comp[2]);
    whi = (NUMW+1)'(2**WW - 1);
    if (comp[3][NUMW]) begin
      w_d = '0;
    end else if (comp[3] > whi) begin
      w_d = WW'(whi);
    end else begin
      w_d = comp[3][WW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (!stall_i) begin
        skid_v_q <= 1'b0;
      end
    end else if (dv_v) begin
      if (out_v_q && stall_i) begin
        skid_v_q <= 1'b1;
      end
      out_v_q <= 1'b1;
    end else if (!stall_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (!stall_i) begin
        x_q <= sx_q;
        y_q <= sy_q;
        z_q <= sz_q;
        w_q <= sw_q;
        p_q <= sp_q;
      end
    end else if (dv_v) begin
      if (out_v_q && stall_i) begin
        sx_q <= x_d;
        sy_q <= y_d;
        sz_q <= z_d;
        sw_q <= w_d;
        sp_q <= dv_side.piv;
      end else begin
        x_q <= x_d;
        y_q <= y_d;
        z_q <= z_d;
        w_q <= w_d;
        p_q <= dv_side.piv;
      end
    end
  end

  assign valid_o       = out_v_q;
  assign quat_x_o      = x_q;
  assign quat_y_o      = y_q;
  assign quat_z_o      = z_q;
  assign quat_w_o      = w_q;
  assign pivot_index_o = p_q;

`ifndef NO_ASSERTIONS
  // The skid register only fills behind a held result.
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_v_q |-> out_v_q)
    else $error("skid register full without a held output");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && stall_i))
    else $error("skid register filled while the output was free");

  // Draining the skid must leave a result on the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && !stall_i |=> out_v_q && !skid_v_q)
    else $error("skid drain lost a transaction");
`endif

endmodule
